FILE: sv/sts_pkg.sv
package sts_pkg;

  localparam int LEAVES_DEF = 1024;
  localparam int IDX_W      = 10;
  localparam int SUM_W      = 32;

  typedef enum logic {
    REQ_ASSIGN = 1'b0,
    REQ_QUERY  = 1'b1
  } req_kind_t;

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_A_WALK = 5'b00100,
    S_Q_WALK = 5'b01000,
    S_Q_DONE = 5'b10000
  } sts_state_t;

endpackage

FILE: sv/sts_node_ram.sv
module sts_node_ram #(
  parameter int AW = 11,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [DW-1:0] rdata_a,
  output logic [DW-1:0] rdata_b
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_a_r;
  logic [DW-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a_r <= mem[raddr_a];
    rdata_b_r <= mem[raddr_b];
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

FILE: sv/segment_tree_range_sum_top.sv
// Channel   Direction  Ports
// in_       input      in_valid, in_stall, in_req_type, in_left_index, in_right_index,
//                      in_leaf_value
// out_      output     out_valid, out_stall, out_range_total
//
// An assign writes the leaf and then walks up to the root, and a query walks its two bounds
// up the tree, one tree level per cycle; each level is one pass through the node memory.
// After reset every word of the node memory is swept to zero, with in_stall high.
// A finished query result sits in an output register; the next item may be taken
// while it waits, but a second query result waits until out_stall releases the first.
module segment_tree_range_sum_top #(
  parameter int LEAVES = sts_pkg::LEAVES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_req_type,
  input  logic [sts_pkg::IDX_W-1:0]        in_left_index,
  input  logic [sts_pkg::IDX_W-1:0]        in_right_index,
  input  logic signed [sts_pkg::SUM_W-1:0] in_leaf_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [sts_pkg::SUM_W-1:0] out_range_total
);

  import sts_pkg::*;

  localparam int LW = $clog2(LEAVES);
  localparam int AW = LW + 1;
  localparam int NW = AW + 1;
  localparam int CW = ((IDX_W > AW) ? IDX_W : AW) + 1;

  sts_state_t state_r, state_nxt;

  logic [AW-1:0]    clr_r, clr_nxt;
  logic [AW-1:0]    pos_r, pos_nxt;
  logic [SUM_W-1:0] cur_r, cur_nxt;
  logic [NW-1:0]    lo_node_r, lo_node_nxt;
  logic [NW-1:0]    hi_node_r, hi_node_nxt;
  logic             pend_a_r, pend_a_nxt;
  logic             pend_b_r, pend_b_nxt;
  logic [SUM_W-1:0] acc_r, acc_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [SUM_W-1:0] out_total_r, out_total_nxt;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [SUM_W-1:0] ram_wdata;
  logic [AW-1:0]    ram_raddr_a;
  logic [AW-1:0]    ram_raddr_b;
  logic [SUM_W-1:0] ram_rdata_a;
  logic [SUM_W-1:0] ram_rdata_b;

  logic             in_xfer;
  logic [CW-1:0]    lo_ext;
  logic [CW-1:0]    hi_ext;
  logic [CW-1:0]    hi_clamp;
  logic             q_empty;
  logic [AW-1:0]    leaf_node;
  logic [AW-1:0]    parent;
  logic [SUM_W-1:0] path_sum;
  logic [NW-1:0]    hi_dec;
  logic [SUM_W-1:0] add_a;
  logic [SUM_W-1:0] add_b;

  sts_node_ram #(
    .AW (AW),
    .DW (SUM_W)
  ) u_node_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_raddr_a),
    .raddr_b (ram_raddr_b),
    .rdata_a (ram_rdata_a),
    .rdata_b (ram_rdata_b)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign lo_ext    = CW'(in_left_index);
  assign hi_ext    = CW'(in_right_index);
  assign hi_clamp  = (hi_ext > CW'(LEAVES - 1)) ? CW'(LEAVES - 1) : hi_ext;
  assign q_empty   = lo_ext > hi_clamp;
  assign leaf_node = AW'(lo_ext) + AW'(LEAVES);
  assign parent    = {1'b0, pos_r[AW-1:1]};
  assign path_sum  = cur_r + ram_rdata_a;
  assign hi_dec    = hi_node_r - NW'(1);
  assign add_a     = pend_a_r ? ram_rdata_a : '0;
  assign add_b     = pend_b_r ? ram_rdata_b : '0;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    pos_nxt       = pos_r;
    cur_nxt       = cur_r;
    lo_node_nxt   = lo_node_r;
    hi_node_nxt   = hi_node_r;
    pend_a_nxt    = pend_a_r;
    pend_b_nxt    = pend_b_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_total_nxt = out_total_r;
    ram_we        = 1'b0;
    ram_waddr     = leaf_node;
    ram_wdata     = SUM_W'(in_leaf_value);
    ram_raddr_a   = lo_node_r[AW-1:0];
    ram_raddr_b   = hi_dec[AW-1:0];

    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          if (in_req_type == REQ_ASSIGN) begin
            if (lo_ext < CW'(LEAVES)) begin
              ram_we      = 1'b1;
              ram_raddr_a = leaf_node ^ AW'(1);
              pos_nxt     = leaf_node;
              cur_nxt     = SUM_W'(in_leaf_value);
              state_nxt   = S_A_WALK;
            end
          end else begin
            acc_nxt     = '0;
            pend_a_nxt  = 1'b0;
            pend_b_nxt  = 1'b0;
            lo_node_nxt = NW'(lo_ext) + NW'(LEAVES);
            hi_node_nxt = NW'(hi_clamp) + NW'(LEAVES) + NW'(1);
            state_nxt   = q_empty ? S_Q_DONE : S_Q_WALK;
          end
        end
      end
      S_A_WALK: begin
        ram_we      = 1'b1;
        ram_waddr   = parent;
        ram_wdata   = path_sum;
        ram_raddr_a = parent ^ AW'(1);
        cur_nxt     = path_sum;
        pos_nxt     = parent;
        if (parent == AW'(1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_Q_WALK: begin
        acc_nxt = acc_r + add_a + add_b;
        if (lo_node_r < hi_node_r) begin
          pend_a_nxt  = lo_node_r[0];
          pend_b_nxt  = hi_node_r[0];
          lo_node_nxt = (lo_node_r + NW'(lo_node_r[0])) >> 1;
          hi_node_nxt = (hi_node_r - NW'(hi_node_r[0])) >> 1;
        end else begin
          pend_a_nxt = 1'b0;
          pend_b_nxt = 1'b0;
          state_nxt  = S_Q_DONE;
        end
      end
      S_Q_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_total_nxt = acc_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      pend_a_r    <= 1'b0;
      pend_b_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      pend_a_r    <= pend_a_nxt;
      pend_b_r    <= pend_b_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r       <= pos_nxt;
    cur_r       <= cur_nxt;
    lo_node_r   <= lo_node_nxt;
    hi_node_r   <= hi_node_nxt;
    acc_r       <= acc_nxt;
    out_total_r <= out_total_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_range_total = signed'(out_total_r);

endmodule

FILE: dv/tb_segment_tree_range_sum_top.sv
module tb_segment_tree_range_sum_top;

  import sts_pkg::*;

  localparam int NUM_LEAVES   = LEAVES_DEF;
  localparam int IDLE_LIMIT   = 20000;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 40;

  class range_sum_scoreboard;
    bit [SUM_W-1:0] leaf_vals [NUM_LEAVES];
    bit [SUM_W-1:0] totals_q [$];
    int mismatches;

    function void report(string what, logic [SUM_W-1:0] exp_v, logic [SUM_W-1:0] got_v);
      mismatches++;
      if (mismatches <= 10) begin
        $display("MISMATCH %s: expected %h, got %h", what, exp_v, got_v);
      end
    endfunction

    function void note_item(req_kind_t kind, logic [IDX_W-1:0] lo, logic [IDX_W-1:0] hi,
                            logic [SUM_W-1:0] val);
      int last;
      bit [SUM_W-1:0] acc;
      if (kind == REQ_ASSIGN) begin
        if (int'(lo) < NUM_LEAVES) begin
          leaf_vals[lo] = val;
        end
      end else begin
        last = (int'(hi) >= NUM_LEAVES) ? NUM_LEAVES - 1 : int'(hi);
        acc = '0;
        for (int i = int'(lo); i <= last; i++) begin
          acc += leaf_vals[i];
        end
        totals_q.push_back(acc);
      end
    endfunction

    function void check_total(logic [SUM_W-1:0] got);
      bit [SUM_W-1:0] exp_v;
      if (totals_q.size() == 0) begin
        report("unexpected range total", 'x, got);
      end else begin
        exp_v = totals_q.pop_front();
        if (got !== exp_v) begin
          report("range_total", exp_v, got);
        end
      end
    endfunction

    function int pending();
      return totals_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_req_type = 1'b0;
  logic [IDX_W-1:0] in_left_index = '0;
  logic [IDX_W-1:0] in_right_index = '0;
  logic signed [SUM_W-1:0] in_leaf_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SUM_W-1:0] out_range_total;

  range_sum_scoreboard sb = new();
  bit calm = 1'b0;
  bit long_hold_req = 1'b0;
  int idle_cycles = 0;

  segment_tree_range_sum_top DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_req_type(in_req_type),
    .in_left_index(in_left_index),
    .in_right_index(in_right_index),
    .in_leaf_value(in_leaf_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_range_total(out_range_total)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = int'($urandom_range(0, 99));
    if (calm || r < 60) begin
      return 0;
    end else if (r < 92) begin
      return int'($urandom_range(1, 3));
    end
    return int'($urandom_range(10, 40));
  endfunction

  task automatic drive_item(req_kind_t kind, logic [IDX_W-1:0] lo, logic [IDX_W-1:0] hi,
                            logic [SUM_W-1:0] val);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= kind;
    in_left_index <= lo;
    in_right_index <= hi;
    in_leaf_value <= val;
    do @(posedge clk); while (in_stall);
    sb.note_item(kind, lo, hi, val);
  endtask

  // Result side: checks every transfer and picks the stall for the next cycle.
  initial begin
    int stall_left;
    int g;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        sb.check_total(out_range_total);
      end
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        g = pick_gap();
        out_stall <= (g > 0);
        if (g > 0) begin
          stall_left = g - 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    req_kind_t kind;
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
    logic [SUM_W-1:0] val;
    int sel;
    int top;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Extremes, wraparound and empty ranges.
    drive_item(REQ_ASSIGN, 10'd0, 10'd1023, 32'h7FFF_FFFF);
    drive_item(REQ_ASSIGN, 10'd1023, 10'd0, 32'h8000_0000);
    drive_item(REQ_ASSIGN, 10'd1, 10'h155, 32'h0000_0001);
    drive_item(REQ_QUERY, 10'd0, 10'd0, 32'hFFFF_FFFF);
    drive_item(REQ_QUERY, 10'd0, 10'd1, 32'h0000_0000);
    drive_item(REQ_QUERY, 10'd1023, 10'd1023, 32'h1234_5678);
    drive_item(REQ_QUERY, 10'd0, 10'd1023, 32'h0000_0000);
    drive_item(REQ_QUERY, 10'd5, 10'd3, 32'hFFFF_FFFF);
    drive_item(REQ_QUERY, 10'd1023, 10'd0, 32'h0000_0000);
    drive_item(REQ_QUERY, 10'd1, 10'd0, 32'h0000_0000);
    drive_item(REQ_ASSIGN, 10'd512, 10'd0, 32'hFFFF_FFFF);
    drive_item(REQ_ASSIGN, 10'd511, 10'd1023, 32'h0000_0001);
    drive_item(REQ_QUERY, 10'd511, 10'd512, 32'h0000_0000);
    drive_item(REQ_QUERY, 10'd1, 10'd1022, 32'h0000_0000);
    drive_item(REQ_ASSIGN, 10'd0, 10'd0, 32'h0000_0000);
    drive_item(REQ_QUERY, 10'd0, 10'd1023, 32'h0000_0000);
    drive_item(REQ_ASSIGN, 10'd1022, 10'h2AA, 32'h5555_5555);
    drive_item(REQ_ASSIGN, 10'h2AA, 10'h155, 32'hAAAA_AAAA);
    drive_item(REQ_QUERY, 10'h2AA, 10'd1022, 32'hAAAA_AAAA);
    drive_item(REQ_QUERY, 10'h155, 10'h3FF, 32'h5555_5555);
    drive_item(REQ_QUERY, 10'd0, 10'd1022, 32'h0000_0000);

    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);

    // The receiver holds off for a long stretch while queries keep coming.
    calm = 1'b1;
    long_hold_req = 1'b1;
    for (int i = 0; i < 30; i++) begin
      lo = IDX_W'($urandom_range(0, NUM_LEAVES - 1));
      drive_item(REQ_QUERY, lo, IDX_W'($urandom_range(int'(lo), NUM_LEAVES - 1)), $urandom);
    end
    calm = 1'b0;

    for (int blk = 0; blk < 12; blk++) begin
      calm = (blk % 3 == 1);
      if (blk == 6) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
      end
      for (int i = 0; i < 50; i++) begin
        kind = ($urandom_range(0, 99) < 45) ? REQ_ASSIGN : REQ_QUERY;
        sel = int'($urandom_range(0, 9));
        lo = IDX_W'($urandom_range(0, NUM_LEAVES - 1));
        if (sel < 4) begin
          hi = IDX_W'($urandom_range(0, NUM_LEAVES - 1));
        end else if (sel < 8) begin
          top = int'(lo) + int'($urandom_range(0, 40));
          hi = (top > NUM_LEAVES - 1) ? IDX_W'(NUM_LEAVES - 1) : IDX_W'(top);
        end else if (sel == 8) begin
          hi = lo;
        end else begin
          hi = IDX_W'(NUM_LEAVES - 1);
        end
        val = $urandom;
        if ($urandom_range(0, 9) == 0) begin
          case ($urandom_range(0, 3))
            0: val = 32'h7FFF_FFFF;
            1: val = 32'h8000_0000;
            2: val = 32'hFFFF_FFFF;
            default: val = 32'h0000_0000;
          endcase
        end
        drive_item(kind, lo, hi, val);
      end
    end
    calm = 1'b0;

    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/sts_pkg.sv
sv/sts_node_ram.sv
sv/segment_tree_range_sum_top.sv
dv/tb_segment_tree_range_sum_top.sv
